// ----- hdl/tflc_pkg.sv -----
// Shared types and constants for the tank fill level controller.
package tflc_pkg;

  localparam int unsigned DIST_W  = 16;
  localparam int unsigned SUM_W   = 20;
  localparam int unsigned CNT_W   = 4;

  localparam logic [DIST_W-1:0] CORR_KNEE = 16'd500;
  localparam logic [DIST_W-1:0] CORR_LOW  = 16'd35;
  localparam logic [DIST_W-1:0] OFS_NEAR  = 16'd35;
  localparam logic [DIST_W-1:0] OFS_FAR   = 16'd15;

  typedef enum logic [1:0] {
    CMD_SAMPLE    = 2'd0,
    CMD_START_CAL = 2'd1,
    CMD_START_FILL= 2'd2,
    CMD_ESTOP     = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE        = 4'd0,
    ST_CALIBRATING = 4'd1,
    ST_CAL_DONE    = 4'd2,
    ST_CAL_FAILED  = 4'd3,
    ST_FILLING     = 4'd4,
    ST_REACHED     = 4'd5,
    ST_UNCAL       = 4'd6,
    ST_TOO_HIGH    = 4'd7,
    ST_SENSOR_LOST = 4'd8,
    ST_ESTOP       = 4'd9
  } status_e;

endpackage

// ----- hdl/tflc_div.sv -----
// Restoring divider, one quotient bit per cycle, for the calibration average.
module tflc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tflc_pkg::SUM_W-1:0]     dividend_i,
  input  logic [tflc_pkg::CNT_W-1:0]     divisor_i,
  output logic                           done_o,
  output logic [tflc_pkg::SUM_W-1:0]     quotient_o
);

  localparam int unsigned STEP_W = $clog2(tflc_pkg::SUM_W);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [STEP_W-1:0]             step_q, step_d;
  logic [tflc_pkg::CNT_W-1:0]    rem_q, rem_d;
  logic [tflc_pkg::SUM_W-1:0]    quo_q, quo_d;
  logic [tflc_pkg::CNT_W-1:0]    div_q, div_d;
  logic [tflc_pkg::CNT_W:0]      trial;
  logic                          fits;

  assign trial = {rem_q, quo_q[tflc_pkg::SUM_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_W'(tflc_pkg::SUM_W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? tflc_pkg::CNT_W'(trial - {1'b0, div_q}) : trial[tflc_pkg::CNT_W-1:0];
      quo_d = {quo_q[tflc_pkg::SUM_W-2:0], fits};
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      div_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      div_q  <= div_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- hdl/tank_fill_level_controller_core.sv -----
// Tank fill level controller: command sequencer, level compare and calibration average.
// Flow: input word registered, executed, then result word loaded into the output registers;
// a calibration that ends with valid samples waits for the bit-serial divider (20 steps).
// A new word is accepted only once the result word is loaded, which stalls on out_ready_i.
// Reset: asynchronous, active low; idle, pump off, stored distance and target cleared.
module tank_fill_level_controller_core #(
  parameter int unsigned SAMPLE_COUNT = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] distance_i,
  input  logic        timed_out_i,
  input  logic        read_error_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        pump_on_o,
  output logic [15:0] level_o,
  output logic [15:0] zero_distance_o,
  output logic [3:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_target_level_i
);

  localparam int unsigned DW = tflc_pkg::DIST_W;
  localparam int unsigned SW = tflc_pkg::SUM_W;
  localparam int unsigned CW = tflc_pkg::CNT_W;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_DONE} state_e;
  typedef enum logic [1:0] {M_IDLE, M_CAL, M_FILL} mode_e;

  state_e              state_q, state_d;
  mode_e               mode_q, mode_d;
  tflc_pkg::cmd_e      cmd_q, cmd_d;
  logic [DW-1:0]       dist_q, dist_d;
  logic                tout_q, tout_d;
  logic                rerr_q, rerr_d;
  logic [DW-1:0]       zero_q, zero_d;
  logic [SW-1:0]       sum_q, sum_d;
  logic [CW-1:0]       slots_q, slots_d;
  logic [CW-1:0]       vcnt_q, vcnt_d;
  logic                pump_q, pump_d;
  logic [DW-1:0]       target_q;
  logic [DW-1:0]       level_q, level_d;
  tflc_pkg::status_e   status_q, status_d;
  logic                ovalid_q, ovalid_d;
  logic                opump_q, opump_d;
  logic [DW-1:0]       olevel_q, olevel_d;
  logic [DW-1:0]       ozero_q, ozero_d;
  tflc_pkg::status_e   ostatus_q, ostatus_d;

  logic [DW-1:0]       corr;
  logic                div_start;
  logic                div_done;
  logic [SW-1:0]       div_quo;

  always_comb begin
    if (dist_q > tflc_pkg::CORR_KNEE) begin
      corr = dist_q - tflc_pkg::OFS_FAR;
    end else if (dist_q > tflc_pkg::CORR_LOW) begin
      corr = dist_q - tflc_pkg::OFS_NEAR;
    end else begin
      corr = dist_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    cmd_d     = cmd_q;
    dist_d    = dist_q;
    tout_d    = tout_q;
    rerr_d    = rerr_q;
    zero_d    = zero_q;
    sum_d     = sum_q;
    slots_d   = slots_q;
    vcnt_d    = vcnt_q;
    pump_d    = pump_q;
    level_d   = level_q;
    status_d  = status_q;
    div_start = 1'b0;
    ovalid_d  = ovalid_q & ~out_ready_i;
    opump_d   = opump_q;
    olevel_d  = olevel_q;
    ozero_d   = ozero_q;
    ostatus_d = ostatus_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = tflc_pkg::cmd_e'(cmd_i);
          dist_d  = distance_i;
          tout_d  = timed_out_i;
          rerr_d  = read_error_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        logic finish;
        finish   = 1'b0;
        level_d  = '0;
        status_d = tflc_pkg::ST_IDLE;
        state_d  = S_DONE;
        if (cmd_q == tflc_pkg::CMD_ESTOP) begin
          if (mode_q == M_CAL) begin
            finish = 1'b1;
          end else begin
            mode_d   = M_IDLE;
            pump_d   = 1'b0;
            status_d = tflc_pkg::ST_ESTOP;
          end
        end else begin
          case (mode_q)
            M_CAL: begin
              status_d = tflc_pkg::ST_CALIBRATING;
              if (cmd_q == tflc_pkg::CMD_SAMPLE) begin
                if (!rerr_q && !tout_q) begin
                  sum_d  = sum_q + SW'(corr);
                  vcnt_d = vcnt_q + 1'b1;
                end
                slots_d = slots_q + 1'b1;
                if (slots_d >= CW'(SAMPLE_COUNT)) begin
                  finish = 1'b1;
                end
              end
            end
            M_FILL: begin
              status_d = tflc_pkg::ST_FILLING;
              if (cmd_q == tflc_pkg::CMD_SAMPLE) begin
                if (rerr_q) begin
                  mode_d   = M_IDLE;
                  pump_d   = 1'b0;
                  status_d = tflc_pkg::ST_SENSOR_LOST;
                end else if (!tout_q) begin
                  level_d = (zero_q > corr) ? zero_q - corr : '0;
                  if (level_d >= target_q) begin
                    mode_d   = M_IDLE;
                    pump_d   = 1'b0;
                    status_d = tflc_pkg::ST_REACHED;
                  end
                end
              end
            end
            default: begin
              if (cmd_q == tflc_pkg::CMD_START_CAL) begin
                mode_d   = M_CAL;
                pump_d   = 1'b0;
                sum_d    = '0;
                slots_d  = '0;
                vcnt_d   = '0;
                status_d = tflc_pkg::ST_CALIBRATING;
              end else if (cmd_q == tflc_pkg::CMD_START_FILL) begin
                if (zero_q == '0) begin
                  status_d = tflc_pkg::ST_UNCAL;
                end else if (target_q > zero_q) begin
                  status_d = tflc_pkg::ST_TOO_HIGH;
                end else begin
                  mode_d   = M_FILL;
                  pump_d   = 1'b1;
                  status_d = tflc_pkg::ST_FILLING;
                end
              end
            end
          endcase
        end
        if (finish) begin
          mode_d = M_IDLE;
          pump_d = 1'b0;
          if (vcnt_d == '0) begin
            zero_d   = '0;
            status_d = tflc_pkg::ST_CAL_FAILED;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          zero_d   = div_quo[DW-1:0];
          status_d = tflc_pkg::ST_CAL_DONE;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d  = 1'b1;
          opump_d   = pump_q;
          olevel_d  = level_q;
          ozero_d   = zero_q;
          ostatus_d = status_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  tflc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (vcnt_d),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mode_q    <= M_IDLE;
      cmd_q     <= tflc_pkg::CMD_SAMPLE;
      dist_q    <= '0;
      tout_q    <= 1'b0;
      rerr_q    <= 1'b0;
      zero_q    <= '0;
      sum_q     <= '0;
      slots_q   <= '0;
      vcnt_q    <= '0;
      pump_q    <= 1'b0;
      target_q  <= '0;
      level_q   <= '0;
      status_q  <= tflc_pkg::ST_IDLE;
      ovalid_q  <= 1'b0;
      opump_q   <= 1'b0;
      olevel_q  <= '0;
      ozero_q   <= '0;
      ostatus_q <= tflc_pkg::ST_IDLE;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      cmd_q     <= cmd_d;
      dist_q    <= dist_d;
      tout_q    <= tout_d;
      rerr_q    <= rerr_d;
      zero_q    <= zero_d;
      sum_q     <= sum_d;
      slots_q   <= slots_d;
      vcnt_q    <= vcnt_d;
      pump_q    <= pump_d;
      level_q   <= level_d;
      status_q  <= status_d;
      ovalid_q  <= ovalid_d;
      opump_q   <= opump_d;
      olevel_q  <= olevel_d;
      ozero_q   <= ozero_d;
      ostatus_q <= ostatus_d;
      if (cfg_valid_i) begin
        target_q <= cfg_target_level_i;
      end
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = ovalid_q;
  assign pump_on_o       = opump_q;
  assign level_o         = olevel_q;
  assign zero_distance_o = ozero_q;
  assign status_o        = ostatus_q;

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the tank fill level controller core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAL_SLOTS    = 10;
  localparam int unsigned RANDOM_WORDS = 1300;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef enum logic [1:0] {
    M_IDLE = 2'd0,
    M_CAL  = 2'd1,
    M_FILL = 2'd2
  } fill_mode_e;

  typedef struct packed {
    tflc_pkg::cmd_e cmd;
    logic [15:0]    dist_mm;
    logic           tout;
    logic           rerr;
  } sensor_word_t;

  typedef struct packed {
    logic              pump;
    logic [15:0]       level;
    logic [15:0]       zero;
    tflc_pkg::status_e status;
  } pump_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = 2'd0;
  logic [15:0] distance_i = 16'd0;
  logic        timed_out_i = 1'b0;
  logic        read_error_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        pump_on_o;
  logic [15:0] level_o;
  logic [15:0] zero_distance_o;
  logic [3:0]  status_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_target_level_i = 16'd0;

  // predicted controller state
  fill_mode_e  mode_m = M_IDLE;
  logic [15:0] zero_m = '0;
  logic [19:0] sum_m = '0;
  logic [3:0]  slots_m = '0;
  logic [3:0]  good_m = '0;
  logic        pump_m = 1'b0;
  logic [15:0] target_m = '0;

  sensor_word_t sensor_q[$];
  pump_word_t   expect_q[$];
  logic [15:0]  target_q[$];

  int unsigned cyc = 0;
  int unsigned n_words = 0;
  int unsigned errors = 0;
  logic        quiet;

  assign quiet = (cyc >= 3000) && (cyc < 8000);

  tank_fill_level_controller_core #(
    .SAMPLE_COUNT(CAL_SLOTS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .cmd_i              (cmd_i),
    .distance_i         (distance_i),
    .timed_out_i        (timed_out_i),
    .read_error_i       (read_error_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .pump_on_o          (pump_on_o),
    .level_o            (level_o),
    .zero_distance_o    (zero_distance_o),
    .status_o           (status_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_target_level_i (cfg_target_level_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [15:0] corrected_mm(logic [15:0] raw);
    if (raw > tflc_pkg::CORR_KNEE) return raw - tflc_pkg::OFS_FAR;
    if (raw > tflc_pkg::CORR_LOW) return raw - tflc_pkg::OFS_NEAR;
    return raw;
  endfunction

  function automatic logic [15:0] level_from(logic [15:0] raw);
    logic [15:0] c;
    c = corrected_mm(raw);
    return (zero_m > c) ? zero_m - c : 16'd0;
  endfunction

  function automatic tflc_pkg::status_e close_calibration();
    mode_m = M_IDLE;
    pump_m = 1'b0;
    if (good_m == 4'd0) begin
      zero_m = '0;
      return tflc_pkg::ST_CAL_FAILED;
    end
    zero_m = 16'(sum_m / 20'(good_m));
    return tflc_pkg::ST_CAL_DONE;
  endfunction

  function automatic pump_word_t predict_fill_word(sensor_word_t w);
    pump_word_t r;
    r.level  = '0;
    r.status = tflc_pkg::ST_IDLE;
    if (w.cmd == tflc_pkg::CMD_ESTOP) begin
      if (mode_m == M_CAL) begin
        r.status = close_calibration();
      end else begin
        mode_m   = M_IDLE;
        pump_m   = 1'b0;
        r.status = tflc_pkg::ST_ESTOP;
      end
    end else if (mode_m == M_CAL) begin
      r.status = tflc_pkg::ST_CALIBRATING;
      if (w.cmd == tflc_pkg::CMD_SAMPLE) begin
        if (!w.rerr && !w.tout) begin
          sum_m  = sum_m + 20'(corrected_mm(w.dist_mm));
          good_m = good_m + 4'd1;
        end
        slots_m = slots_m + 4'd1;
        if (slots_m >= 4'(CAL_SLOTS)) r.status = close_calibration();
      end
    end else if (mode_m == M_FILL) begin
      r.status = tflc_pkg::ST_FILLING;
      if (w.cmd == tflc_pkg::CMD_SAMPLE) begin
        if (w.rerr) begin
          mode_m   = M_IDLE;
          pump_m   = 1'b0;
          r.status = tflc_pkg::ST_SENSOR_LOST;
        end else if (!w.tout) begin
          r.level = level_from(w.dist_mm);
          if (r.level >= target_m) begin
            mode_m   = M_IDLE;
            pump_m   = 1'b0;
            r.status = tflc_pkg::ST_REACHED;
          end
        end
      end
    end else begin
      if (w.cmd == tflc_pkg::CMD_START_CAL) begin
        mode_m   = M_CAL;
        pump_m   = 1'b0;
        sum_m    = '0;
        slots_m  = '0;
        good_m   = '0;
        r.status = tflc_pkg::ST_CALIBRATING;
      end else if (w.cmd == tflc_pkg::CMD_START_FILL) begin
        if (zero_m == 16'd0) begin
          r.status = tflc_pkg::ST_UNCAL;
        end else if (target_m > zero_m) begin
          r.status = tflc_pkg::ST_TOO_HIGH;
        end else begin
          mode_m   = M_FILL;
          pump_m   = 1'b1;
          r.status = tflc_pkg::ST_FILLING;
        end
      end
    end
    r.pump = pump_m;
    r.zero = zero_m;
    return r;
  endfunction

  // input driver
  always @(posedge clk_i) begin
    sensor_word_t nxt;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        expect_q.push_back(predict_fill_word('{tflc_pkg::cmd_e'(cmd_i), distance_i,
                                               timed_out_i, read_error_i}));
      if (!in_valid_i || in_ready_o) begin
        if (sensor_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 16)) begin
          nxt = sensor_q.pop_front();
          in_valid_i   <= 1'b1;
          cmd_i        <= nxt.cmd;
          distance_i   <= nxt.dist_mm;
          timed_out_i  <= nxt.tout;
          read_error_i <= nxt.rerr;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // target register writes
  always @(posedge clk_i) begin
    logic [15:0] v;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) target_m = cfg_target_level_i;
      if (!cfg_valid_i || cfg_ready_o) begin
        if (target_q.size() != 0) begin
          v = target_q.pop_front();
          cfg_valid_i        <= 1'b1;
          cfg_target_level_i <= v;
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) out_ready_i <= rst_ni && (quiet || $urandom_range(0, 99) >= 16);

  // result monitor
  always @(posedge clk_i) begin
    pump_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expect_q.size() == 0) begin
        $error("result word with none pending: status %0d level %0d", status_o, level_o);
        errors++;
      end else begin
        want = expect_q.pop_front();
        if (pump_on_o !== want.pump) begin
          $error("pump_on: expected %0d, got %0d", want.pump, pump_on_o);
          errors++;
        end
        if (level_o !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, level_o);
          errors++;
        end
        if (zero_distance_o !== want.zero) begin
          $error("zero_distance: expected %0d, got %0d", want.zero, zero_distance_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic queue_word(tflc_pkg::cmd_e c, logic [15:0] d, logic t, logic e);
    sensor_q.push_back('{c, d, t, e});
    n_words++;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (sensor_q.size() != 0 || in_valid_i || expect_q.size() != 0 ||
           target_q.size() != 0 || cfg_valid_i);
  endtask

  task automatic settle_idle();
    wait_drained();
    if (mode_m != M_IDLE) begin
      queue_word(tflc_pkg::CMD_ESTOP, 16'($urandom), 1'($urandom), 1'($urandom));
      wait_drained();
    end
  endtask

  task automatic write_target(logic [15:0] v);
    target_q.push_back(v);
    wait_drained();
  endtask

  function automatic logic [15:0] clamp_mm(int v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  task automatic cal_burst();
    int          base;
    int          abort_at;
    int          r;
    int          bad;
    logic        all_bad;
    r = $urandom_range(0, 99);
    if (r < 50)      base = $urandom_range(36, 3000);
    else if (r < 70) base = $urandom_range(0, 65535);
    else if (r < 80) base = $urandom_range(0, 35);
    else if (r < 90) base = $urandom_range(480, 520);
    else             base = $urandom_range(65000, 65535);
    all_bad  = ($urandom_range(0, 19) == 0);
    abort_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, CAL_SLOTS - 1) : CAL_SLOTS;
    queue_word(tflc_pkg::CMD_START_CAL, 16'($urandom), 1'($urandom), 1'($urandom));
    for (int s = 0; s < abort_at; s++) begin
      if ($urandom_range(0, 19) == 0)
        queue_word($urandom_range(0, 1) ? tflc_pkg::CMD_START_CAL : tflc_pkg::CMD_START_FILL,
                   16'($urandom), 1'($urandom), 1'($urandom));
      if (all_bad || $urandom_range(0, 99) < 12) begin
        bad = $urandom_range(1, 3);
        queue_word(tflc_pkg::CMD_SAMPLE, 16'($urandom), bad[0], bad[1]);
      end else begin
        queue_word(tflc_pkg::CMD_SAMPLE, clamp_mm(base + $urandom_range(0, 20) - 10),
                   1'b0, 1'b0);
      end
    end
    if (abort_at < CAL_SLOTS)
      queue_word(tflc_pkg::CMD_ESTOP, 16'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic fill_burst();
    int          r;
    int          k;
    int          step;
    int          start;
    logic [15:0] d;
    logic        done;
    r = $urandom_range(0, 99);
    if (zero_m == 16'd0 || r < 10) write_target(16'($urandom));
    else if (r < 20)               write_target(16'd0);
    else if (r < 28)               write_target(zero_m);
    else if (r < 36)
      write_target((zero_m == 16'hFFFF) ? 16'hFFFF : 16'($urandom_range(zero_m + 1, 65535)));
    else                           write_target(16'($urandom_range(1, zero_m)));
    repeat ($urandom_range(1, 3)) begin
      queue_word(tflc_pkg::CMD_START_FILL, 16'($urandom), 1'($urandom), 1'($urandom));
      if (zero_m != 16'd0 && target_m <= zero_m) begin
        step  = (target_m == 16'd0) ? 1 : int'(target_m) / $urandom_range(2, 12);
        step  = (step < 1) ? 1 : step;
        start = (zero_m >= 16'd486) ? int'(zero_m) + 15 : int'(zero_m) + 35;
        k     = 0;
        done  = 1'b0;
        while (!done) begin
          r = $urandom_range(0, 99);
          k++;
          if (k > 40 || r < 2) begin
            queue_word(tflc_pkg::CMD_ESTOP, 16'($urandom), 1'($urandom), 1'($urandom));
            done = 1'b1;
          end else if (r < 5) begin
            queue_word(tflc_pkg::CMD_SAMPLE, 16'($urandom), 1'($urandom), 1'b1);
            done = 1'b1;
          end else if (r < 8) begin
            queue_word((r == 5) ? tflc_pkg::CMD_START_CAL : tflc_pkg::CMD_START_FILL,
                       16'($urandom), 1'($urandom), 1'($urandom));
          end else if (r < 16) begin
            queue_word(tflc_pkg::CMD_SAMPLE, 16'($urandom), 1'b1, 1'b0);
          end else begin
            d = clamp_mm(start - k * step + $urandom_range(0, 6) - 3);
            queue_word(tflc_pkg::CMD_SAMPLE, d, 1'b0, 1'b0);
            done = (level_from(d) >= target_m);
          end
        end
      end
      if ($urandom_range(0, 3) == 0)
        queue_word(tflc_pkg::CMD_SAMPLE, 16'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(15, 30))
      queue_word(tflc_pkg::cmd_e'($urandom_range(0, 3)), 16'($urandom), 1'($urandom),
                 1'($urandom));
  endtask

  initial begin
    int   pick;
    int   first;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // uncalibrated: idle sample, refused fill, estop, busy start, empty calibration
    queue_word(tflc_pkg::CMD_SAMPLE, 16'hFFFF, 1'b1, 1'b1);
    queue_word(tflc_pkg::CMD_START_FILL, 16'd0, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_ESTOP, 16'd0, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_START_CAL, 16'd0, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_START_FILL, 16'd0, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_SAMPLE, 16'd100, 1'b0, 1'b1);
    queue_word(tflc_pkg::CMD_SAMPLE, 16'd100, 1'b1, 1'b0);
    queue_word(tflc_pkg::CMD_ESTOP, 16'd0, 1'b0, 1'b0);
    // full calibration across the correction knees
    queue_word(tflc_pkg::CMD_START_CAL, 16'd0, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_SAMPLE, 16'd0, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_SAMPLE, 16'd35, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_SAMPLE, 16'd36, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_SAMPLE, 16'd500, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_SAMPLE, 16'd501, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_SAMPLE, 16'hFFFF, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_SAMPLE, 16'hFFFF, 1'b0, 1'b1);
    queue_word(tflc_pkg::CMD_SAMPLE, 16'd1000, 1'b1, 1'b0);
    queue_word(tflc_pkg::CMD_SAMPLE, 16'hFFFF, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_SAMPLE, 16'hFFFF, 1'b0, 1'b0);
    settle_idle();

    write_target(16'hFFFF);
    queue_word(tflc_pkg::CMD_START_FILL, 16'd0, 1'b0, 1'b0);
    settle_idle();

    // fill: busy start, timeout, low level, reached, sensor lost, estop
    write_target(16'd100);
    queue_word(tflc_pkg::CMD_START_FILL, 16'd0, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_START_CAL, 16'd0, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_SAMPLE, 16'd0, 1'b1, 1'b0);
    queue_word(tflc_pkg::CMD_SAMPLE, 16'd24700, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_SAMPLE, 16'd0, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_START_FILL, 16'd0, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_SAMPLE, 16'd0, 1'b1, 1'b1);
    queue_word(tflc_pkg::CMD_START_FILL, 16'd0, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_ESTOP, 16'd0, 1'b0, 1'b0);
    // calibration cut short after one good sample
    queue_word(tflc_pkg::CMD_START_CAL, 16'd0, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_SAMPLE, 16'd40, 1'b0, 1'b0);
    queue_word(tflc_pkg::CMD_ESTOP, 16'd0, 1'b0, 1'b0);
    settle_idle();

    first = n_words;
    while (n_words - first < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        cal_burst();
        settle_idle();
        fill_burst();
      end else if (pick < 75) begin
        fill_burst();
      end else if (pick < 90) begin
        cal_burst();
      end else begin
        noise_burst();
      end
      settle_idle();
    end

    repeat (40) @(negedge clk_i);
    if (errors == 0 && expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
